>>> rtl/bounded_uniform_rejection_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded uniform rejection unit
// Clocked, reset-gated property wrappers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNIFORM_REJECTION_UNIT_MACROS_SVH
`define BOUNDED_UNIFORM_REJECTION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BURS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("burs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BURS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("burs assertion failed");

`endif

>>> rtl/burs_pkg.sv
// ----------------------------------------------------------------------------
// burs_pkg
// Shared types, register indexes and chunk helpers of the rejection unit.
// ----------------------------------------------------------------------------
package burs_pkg;

  // Configuration register indexes
  localparam logic REG_BOUND = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam logic [63:0] BOUND_MAX8  = 64'h0000_0000_0000_00FF;
  localparam logic [63:0] BOUND_MAX16 = 64'h0000_0000_0000_FFFF;
  localparam logic [63:0] BOUND_MAX32 = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [1:0] {CW8, CW16, CW32, CW64} chunk_w_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_THRESH, ST_CHECK, ST_MOD, ST_FLUSH
  } state_e;

  // Request into the serial remainder unit; dividend is MSB-aligned.
  typedef struct packed {
    logic        start;
    logic [6:0]  nbits;
    logic [64:0] dividend;
  } rem_req_t;

  // Load request into the output register.
  typedef struct packed {
    logic        load;
    logic [63:0] value;
    logic        last;
    logic        done;
  } out_load_t;

  function automatic chunk_w_e width_sel(input logic [63:0] bound);
    chunk_w_e cw;
    if (bound <= BOUND_MAX8) begin
      cw = CW8;
    end else if (bound <= BOUND_MAX16) begin
      cw = CW16;
    end else if (bound <= BOUND_MAX32) begin
      cw = CW32;
    end else begin
      cw = CW64;
    end
    return cw;
  endfunction

  function automatic logic [6:0] cw_bits(input chunk_w_e cw);
    logic [6:0] n;
    unique case (cw)
      CW8:     n = 7'd8;
      CW16:    n = 7'd16;
      CW32:    n = 7'd32;
      default: n = 7'd64;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] cw_chunks_m1(input chunk_w_e cw);
    logic [2:0] n;
    unique case (cw)
      CW8:     n = 3'd7;
      CW16:    n = 3'd3;
      CW32:    n = 3'd1;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Low chunk of the word, zero extended.
  function automatic logic [63:0] chunk_of(input chunk_w_e cw, input logic [63:0] w);
    logic [63:0] c;
    unique case (cw)
      CW8:     c = {56'd0, w[7:0]};
      CW16:    c = {48'd0, w[15:0]};
      CW32:    c = {32'd0, w[31:0]};
      default: c = w;
    endcase
    return c;
  endfunction

  // Low chunk placed at the top of a 65-bit dividend register.
  function automatic logic [64:0] chunk_align(input chunk_w_e cw, input logic [63:0] w);
    logic [64:0] a;
    unique case (cw)
      CW8:     a = {w[7:0], 57'd0};
      CW16:    a = {w[15:0], 49'd0};
      CW32:    a = {w[31:0], 33'd0};
      default: a = {w, 1'b0};
    endcase
    return a;
  endfunction

  function automatic logic [63:0] chunk_shift(input chunk_w_e cw, input logic [63:0] w);
    logic [63:0] s;
    unique case (cw)
      CW8:     s = {8'd0, w[63:8]};
      CW16:    s = {16'd0, w[63:16]};
      CW32:    s = {32'd0, w[63:32]};
      default: s = w;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/burs_rem.sv
// ----------------------------------------------------------------------------
// burs_rem
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module burs_rem import burs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rem_req_t    req_i,
  input  logic [63:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] rem_o
);

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] div_q;
  logic [63:0] rem_q;
  logic [64:0] trial;
  logic [64:0] diff;
  logic [63:0] rem_next;

  // Shift in the next bit, subtract when the partial remainder reaches the divisor
  assign trial    = {rem_q, div_q[64]};
  assign diff     = trial - {1'b0, divisor_i};
  assign rem_next = (trial >= {1'b0, divisor_i}) ? diff[63:0] : trial[63:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
    end else if (busy_q) begin
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= 64'd0;
      div_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= rem_next;
      div_q <= {div_q[63:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/burs_out_reg.sv
// ----------------------------------------------------------------------------
// burs_out_reg
// Output register of the result channel, decoupling the sender from stalls.
// ----------------------------------------------------------------------------
module burs_out_reg import burs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  out_load_t   ld_i,
  input  logic        ready_i,
  output logic        free_o,
  output logic        valid_o,
  output logic [63:0] value_o,
  output logic        last_o,
  output logic        done_o
);

  logic        valid_q;
  logic [63:0] value_q;
  logic        last_q;
  logic        done_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ld_i.load) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.load) begin
      value_q <= ld_i.value;
      last_q  <= ld_i.last;
      done_q  <= ld_i.done;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign last_o  = last_q;
  assign done_o  = done_q;

endmodule

>>> rtl/bounded_uniform_rejection_unit.sv
// ----------------------------------------------------------------------------
// bounded_uniform_rejection_unit
// Uniform integers below a configured bound from raw 64-bit random words.
// ----------------------------------------------------------------------------
// Input channel: one 64-bit random word per transaction (in_valid_i/in_ready_o).
// Output channel: value_o, last_o, done_res_o per transaction
//   (out_valid_o/out_ready_i); a word yields zero to eight results.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0: bound, 1: count_wanted). Write only while the block is idle.
// Datapath: all arithmetic runs through one bit-serial remainder unit, one bit
//   per cycle. The chunk width W is 8/16/32/64 bits, chosen from the bound.
//   A zero bound consumes the word with no result.
// The last result of a word is held in a pending register until the word is
//   finished, so last_o can be set on it.
// Reset: bound = 2, count_wanted = 1, request count cleared, channels empty.
// Stall: the output register takes the next result while the pending register
//   holds one more; beyond that the sequencer waits. A new word is taken once
//   the previous one is finished, even while a result waits in the output.
// ----------------------------------------------------------------------------
`include "bounded_uniform_rejection_unit_macros.svh"

module bounded_uniform_rejection_unit import burs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] random_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic        last_o,
  output logic        done_res_o
);

  // Configuration registers
  logic [63:0] bound_q;
  logic [30:0] count_q;

  // Sequencer state
  state_e      state_q, state_d;
  logic [63:0] word_q, word_d;
  logic [63:0] thresh_q, thresh_d;
  logic [2:0]  left_q, left_d;
  chunk_w_e    cw_q, cw_d;
  logic [30:0] produced_q, produced_d;
  logic        pend_valid_q, pend_valid_d;
  logic [63:0] pend_value_q, pend_value_d;
  logic        pend_done_q, pend_done_d;

  logic [30:0] produced_next;
  logic        req_done;

  rem_req_t    rem_req;
  logic        rem_busy;
  logic [63:0] rem_val;
  out_load_t   out_ld;
  logic        out_free;

  burs_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (rem_req),
    .divisor_i (bound_q),
    .busy_o    (rem_busy),
    .rem_o     (rem_val)
  );

  burs_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_i    (out_ld),
    .ready_i (out_ready_i),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .value_o (value_o),
    .last_o  (last_o),
    .done_o  (done_res_o)
  );

  // Request bookkeeping: counter wraps in 31 bits, completion by >=
  assign produced_next = produced_q + 31'd1;
  assign req_done      = (produced_next >= count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= 64'd2;
      count_q <= 31'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOUND: bound_q <= cfg_data_i;
        REG_COUNT: count_q <= cfg_data_i[30:0];
        default:   bound_q <= bound_q;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    word_d       = word_q;
    thresh_d     = thresh_q;
    left_d       = left_q;
    cw_d         = cw_q;
    produced_d   = produced_q;
    pend_valid_d = pend_valid_q;
    pend_value_d = pend_value_q;
    pend_done_d  = pend_done_q;
    rem_req      = '0;
    out_ld       = '0;
    in_ready_o   = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          word_d = random_word_i;
          cw_d   = width_sel(bound_q);
          // A zero bound accepts nothing: drop the word
          if (bound_q != 64'd0) begin
            // Threshold is 2^W mod bound: a one followed by W zeros
            rem_req.start    = 1'b1;
            rem_req.nbits    = cw_bits(cw_d) + 7'd1;
            rem_req.dividend = {1'b1, 64'd0};
            state_d          = ST_THRESH;
          end
        end
      end

      ST_THRESH: begin
        if (!rem_busy) begin
          thresh_d = rem_val;
          left_d   = cw_chunks_m1(cw_q);
          state_d  = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (chunk_of(cw_q, word_q) >= thresh_q) begin
          rem_req.start    = 1'b1;
          rem_req.nbits    = cw_bits(cw_q);
          rem_req.dividend = chunk_align(cw_q, word_q);
          state_d          = ST_MOD;
        end else if (left_q == 3'd0) begin
          state_d = ST_FLUSH;
        end else begin
          word_d = chunk_shift(cw_q, word_q);
          left_d = left_q - 3'd1;
        end
      end

      ST_MOD: begin
        // Hold the new result until the previous one can move on
        if (!rem_busy && (!pend_valid_q || out_free)) begin
          if (pend_valid_q) begin
            out_ld.load  = 1'b1;
            out_ld.value = pend_value_q;
            out_ld.last  = 1'b0;
            out_ld.done  = pend_done_q;
          end
          pend_valid_d = 1'b1;
          pend_value_d = rem_val;
          pend_done_d  = req_done;
          produced_d   = req_done ? 31'd0 : produced_next;
          if (req_done || (left_q == 3'd0)) begin
            state_d = ST_FLUSH;
          end else begin
            word_d  = chunk_shift(cw_q, word_q);
            left_d  = left_q - 3'd1;
            state_d = ST_CHECK;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_ld.load  = 1'b1;
          out_ld.value = pend_value_q;
          out_ld.last  = 1'b1;
          out_ld.done  = pend_done_q;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      produced_q   <= 31'd0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      produced_q   <= produced_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    thresh_q     <= thresh_d;
    left_q       <= left_d;
    cw_q         <= cw_d;
    pend_value_q <= pend_value_d;
    pend_done_q  <= pend_done_d;
  end

  // Assertions
  `BURS_ASSERT_NOW(a_idle_no_pending, clk_i, rst_ni, state_q == ST_IDLE, !pend_valid_q)
  `BURS_ASSERT_NOW(a_rem_busy_state, clk_i, rst_ni, rem_busy,
                   (state_q == ST_THRESH) || (state_q == ST_MOD))
  `BURS_ASSERT_NEXT(a_done_ends_word, clk_i, rst_ni,
                    (state_q == ST_MOD) && (state_d == ST_CHECK), !pend_done_q)
  `BURS_ASSERT_NOW(a_load_has_pending, clk_i, rst_ni, out_ld.load, pend_valid_q)

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Testbench of the bounded uniform rejection unit
// Feeds raw 64-bit words through the input channel and checks each value,
// last and done_res flag against an in-bench prediction of the chunking,
// rejection threshold, modulo and request counting.
// ----------------------------------------------------------------------------
module tb;
  import burs_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  // margin for a word that yields nothing to run out after the last value
  localparam int unsigned DRAIN_CYCLES    = 300;
  localparam int unsigned RAND_PHASES     = 10;
  localparam int unsigned WORDS_PER_PHASE = 26;
  localparam int unsigned QUIET_PHASE     = 4;

  typedef struct packed {
    logic [63:0] value;
    logic        last;
    logic        done;
  } draw_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] random_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] value_o;
  logic        last_o;
  logic        done_res_o;

  // Shadow of the block's registers and request counter
  logic [63:0] cfg_bound;
  logic [30:0] cfg_count;
  logic [30:0] req_produced;

  draw_t       expected_draws[$];
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  bit          idle_in     = 1'b1;
  bit          stall_out   = 1'b1;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bounded_uniform_rejection_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .random_word_i (random_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .last_o        (last_o),
    .done_res_o    (done_res_o)
  );

  // --------------------------------------------------------------------------
  // Prediction: cut the word into chunks low first, reject chunks below
  // 2^width mod bound, reduce the rest modulo bound and count them against
  // the request length. The value closing a request drops the rest of the
  // word; the final value of the word carries last.
  // --------------------------------------------------------------------------
  function automatic void predict_draws(input logic [63:0] word);
    int unsigned chunk_bits;
    logic [63:0] chunk_mask;
    logic [63:0] reject_below;
    logic [63:0] rest;
    logic [63:0] chunk;
    logic [30:0] next_count;
    draw_t       draw;
    int unsigned queued;

    // a zero bound accepts nothing and leaves the count alone
    if (cfg_bound == 64'd0) return;

    if (cfg_bound <= 64'h0000_0000_0000_00FF) begin
      chunk_bits = 8;
    end else if (cfg_bound <= 64'h0000_0000_0000_FFFF) begin
      chunk_bits = 16;
    end else if (cfg_bound <= 64'h0000_0000_FFFF_FFFF) begin
      chunk_bits = 32;
    end else begin
      chunk_bits = 64;
    end

    if (chunk_bits == 64) begin
      chunk_mask   = '1;
      // 2^64 mod bound, computed as (2^64 - bound) mod bound
      reject_below = (64'd0 - cfg_bound) % cfg_bound;
    end else begin
      chunk_mask   = (64'd1 << chunk_bits) - 64'd1;
      reject_below = (64'd1 << chunk_bits) % cfg_bound;
    end

    queued = expected_draws.size();
    rest   = word;
    for (int k = 0; k < 64 / chunk_bits; k++) begin
      chunk = rest & chunk_mask;
      if (chunk >= reject_below) begin
        next_count = req_produced + 31'd1;
        draw.value = chunk % cfg_bound;
        draw.last  = 1'b0;
        // >= so that a zero or lowered request length closes at once
        draw.done  = (next_count >= cfg_count);
        expected_draws.push_back(draw);
        if (draw.done) begin
          req_produced = '0;
          break;
        end
        req_produced = next_count;
      end
      if (chunk_bits < 64) rest = rest >> chunk_bits;
    end

    if (expected_draws.size() > queued) begin
      expected_draws[expected_draws.size() - 1].last = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Called at a rising edge; returns at the edge where the
  // transaction is accepted, with valid still high so that back-to-back
  // words never drop it.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [63:0] word);
    while (idle_in && ($urandom_range(99) < 19)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    random_word_i <= word;
    // ready is settled by the falling edge; the next rising edge takes it
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    predict_draws(word);
  endtask

  // Drop valid, wait for every expected value, then let any word that yields
  // nothing run out before touching the registers.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers on consecutive edges; only called while idle.
  task automatic set_config(input logic [63:0] bound, input logic [63:0] count_data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_BOUND;
    cfg_data_i <= bound;
    @(posedge clk_i);
    cfg_bound  = bound;
    cfg_idx_i  <= REG_COUNT;
    cfg_data_i <= count_data;
    @(posedge clk_i);
    cfg_count  = count_data[30:0];
    cfg_we_i   <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output side: randomly hold off ready, compare each transaction with the
  // oldest expectation.
  // --------------------------------------------------------------------------
  task automatic check_draw();
    draw_t want;
    if (expected_draws.size() == 0) begin
      $error("unexpected result: value %h last %b done_res %b",
             value_o, last_o, done_res_o);
      err_count++;
    end else begin
      want = expected_draws.pop_front();
      if (value_o !== want.value) begin
        $error("value: expected %h, actual %h", want.value, value_o);
        err_count++;
      end
      if (last_o !== want.last) begin
        $error("last: expected %b, actual %b", want.last, last_o);
        err_count++;
      end
      if (done_res_o !== want.done) begin
        $error("done_res: expected %b, actual %b", want.done, done_res_o);
        err_count++;
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      out_ready_i <= !(stall_out && ($urandom_range(99) < 19));
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) check_draw();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL bounded_uniform_rejection_unit");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] pick_bound();
    logic [63:0] bnd;
    logic [63:0] bound_edges [8] = '{
      64'd1, 64'hFF, 64'h100, 64'hFFFF, 64'h1_0000,
      64'hFFFF_FFFF, 64'h1_0000_0000, '1
    };
    int unsigned half_bits;
    case ($urandom_range(9))
      0: bnd = 64'($urandom_range(65535, 256));
      1: bnd = 64'($urandom_range(32'hFFFF_FFFF, 32'h1_0000));
      2: bnd = {$urandom, $urandom} | 64'h1_0000_0000;
      3: begin
        // just above half the chunk range: close to half the chunks rejected
        half_bits = 8 << $urandom_range(3);
        bnd = (64'd1 << (half_bits - 1)) + 64'($urandom_range(15, 1));
      end
      4: bnd = bound_edges[$urandom_range(7)];
      5: bnd = ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(255, 1));
      default: bnd = 64'($urandom_range(255, 1));
    endcase
    return bnd;
  endfunction

  function automatic logic [30:0] pick_count();
    logic [30:0] cnt;
    case ($urandom_range(7))
      0: cnt = '0;
      1: cnt = 31'($urandom_range(5000, 10));
      2: cnt = 31'h7FFF_FFFF;
      default: cnt = 31'($urandom_range(9, 1));
    endcase
    return cnt;
  endfunction

  function automatic logic [63:0] pick_word();
    logic [63:0] word;
    logic [63:0] keep;
    word = {$urandom, $urandom};
    case ($urandom_range(9))
      0: begin
        // clear whole bytes to push chunks under the rejection threshold
        for (int b = 0; b < 8; b++) keep[8 * b +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
        word = word & keep;
      end
      1: word = $urandom_range(1) ? 64'd0 : '1;
      default: ;
    endcase
    return word;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: bound 2 in 8-bit chunks, one value per request.
  task automatic test_defaults();
    send_word(64'd0);
    send_word('1);
  endtask

  // Each chunk width at both ends, plus two bounds with heavy rejection.
  task automatic test_width_edges();
    logic [63:0] bound_edges [10] = '{
      64'd1, 64'hFF, 64'h100, 64'hFFFF, 64'h1_0000, 64'hFFFF_FFFF,
      64'h1_0000_0000, '1, 64'd129, 64'h8000_0000_0000_0001
    };
    foreach (bound_edges[i]) begin
      quiesce();
      set_config(bound_edges[i], 64'd5);
      send_word(64'h0000_FFFF_FFFF_0000);
    end
  endtask

  // A zero bound swallows words with no result.
  task automatic test_zero_bound();
    quiesce();
    set_config(64'd0, 64'd1);
    send_word(64'd0);
    send_word('1);
  endtask

  // Zero length, maximum length, then a shorter length and a new bound while
  // a request is half done: the next value must close the request.
  task automatic test_count_edges();
    quiesce();
    set_config(64'd2, 64'hFFFF_FFFF_8000_0000);
    send_word(64'h0123_4567_89AB_CDEF);
    send_word('1);
    quiesce();
    set_config(64'd2, 64'h0000_0000_7FFF_FFFF);
    send_word('1);
    quiesce();
    set_config(64'd7, 64'd3);
    send_word('1);
  endtask

  // Random phases, each with fresh registers; one phase runs without any
  // idling on either side. The request count carries across phases.
  task automatic test_random();
    logic [63:0] bnd;
    logic [30:0] cnt;
    for (int p = 0; p < RAND_PHASES; p++) begin
      quiesce();
      bnd = pick_bound();
      cnt = pick_count();
      idle_in   = (p != QUIET_PHASE);
      stall_out = (p != QUIET_PHASE);
      set_config(bnd, {$urandom, 1'($urandom), cnt});
      for (int i = 0; i < WORDS_PER_PHASE; i++) send_word(pick_word());
    end
    idle_in   = 1'b1;
    stall_out = 1'b1;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_BOUND;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    random_word_i <= '0;
    out_ready_i   <= 1'b0;
    cfg_bound     = 64'd2;
    cfg_count     = 31'd1;
    req_produced  = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_width_edges();
    test_zero_bound();
    test_count_edges();
    test_random();

    // anything still expected here runs into the cycle limit
    quiesce();
    if (err_count == 0) begin
      $display("PASS bounded_uniform_rejection_unit");
    end else begin
      $display("FAIL bounded_uniform_rejection_unit");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/burs_pkg.sv
rtl/burs_rem.sv
rtl/burs_out_reg.sv
rtl/bounded_uniform_rejection_unit.sv
test/tb.sv
